[sv/msp_pkg.sv]
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants of the acknowledgement header parser
// result kinds, queue entry layout and queue sizing
// ----------------------------------------------------------------------------
package msp_pkg;

  // longest property length field in bytes (1 to 4)
  localparam int MAX_LEN_BYTES = 4;
  localparam int LEN_W         = 28;
  localparam int ID_W          = 16;

  // queue between parser and output stage
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PROPERTY  = 2'd0,
    KIND_COMPLETE  = 2'd1,
    KIND_MALFORMED = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [ID_W-1:0]  packet_id;
    logic [7:0]       reason_code;
    logic [7:0]       property_byte;
    logic             eop;
  } entry_t;

endpackage

[sv/msp_front.sv]
// ----------------------------------------------------------------------------
// msp_front: byte parser
// walks id, length, property and reason phases and queues at most one result per byte
// ----------------------------------------------------------------------------
module msp_front import msp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic [7:0]   in_byte,
  input  logic         in_start,
  input  logic         q_ready,
  output logic         push,
  output entry_t       push_entry
);

  typedef enum logic [2:0] {
    PH_ID_HIGH = 3'd0,
    PH_ID_LOW  = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PROPS   = 3'd3,
    PH_REASON  = 3'd4,
    PH_IDLE    = 3'd5
  } phase_t;

  phase_t            phase_r, phase_nxt, cur_phase;
  logic [ID_W-1:0]   id_r, id_nxt, cur_id;
  logic [LEN_W-1:0]  len_r, len_nxt, cur_len, merged;
  logic [1:0]        k_r, k_nxt, cur_k;
  logic              accept;

  assign accept = in_valid && q_ready;

  always_comb begin
    // a start mark clears parse state before the byte is used
    cur_phase = in_start ? PH_ID_HIGH : phase_r;
    cur_id    = in_start ? '0 : id_r;
    cur_len   = in_start ? '0 : len_r;
    cur_k     = in_start ? '0 : k_r;

    unique case (cur_k)
      2'd0: merged = cur_len | {21'd0, in_byte[6:0]};
      2'd1: merged = cur_len | {14'd0, in_byte[6:0], 7'd0};
      2'd2: merged = cur_len | {7'd0, in_byte[6:0], 14'd0};
      default: merged = cur_len | {in_byte[6:0], 21'd0};
    endcase

    phase_nxt  = phase_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    k_nxt      = k_r;
    push       = 1'b0;
    push_entry = '{kind: KIND_PROPERTY, packet_id: '0, reason_code: '0,
                   property_byte: '0, eop: 1'b0};

    if (accept) begin
      phase_nxt = cur_phase;
      id_nxt    = cur_id;
      len_nxt   = cur_len;
      k_nxt     = cur_k;
      case (cur_phase)
        PH_ID_HIGH: begin
          id_nxt    = {in_byte, 8'd0};
          phase_nxt = PH_ID_LOW;
        end
        PH_ID_LOW: begin
          id_nxt    = {cur_id[15:8], in_byte};
          phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_nxt = merged;
          if (!in_byte[7]) begin
            phase_nxt = (merged == '0) ? PH_REASON : PH_PROPS;
          end else if ((3'({1'b0, cur_k}) + 3'd1) >= 3'(MAX_LEN_BYTES)) begin
            // continuation bit still set on the last allowed length byte
            phase_nxt       = PH_IDLE;
            push            = 1'b1;
            push_entry.kind = KIND_MALFORMED;
            push_entry.eop  = 1'b1;
          end else begin
            k_nxt = cur_k + 2'd1;
          end
        end
        PH_PROPS: begin
          len_nxt = cur_len - LEN_W'(1);
          if (cur_len == LEN_W'(1)) begin
            phase_nxt = PH_REASON;
          end
          push                     = 1'b1;
          push_entry.property_byte = in_byte;
        end
        PH_REASON: begin
          phase_nxt              = PH_IDLE;
          push                   = 1'b1;
          push_entry.kind        = KIND_COMPLETE;
          push_entry.packet_id   = cur_id;
          push_entry.reason_code = in_byte;
          push_entry.eop         = 1'b1;
        end
        default: begin
          // idle: bytes after the end of a packet are dropped
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ID_HIGH;
      id_r    <= '0;
      len_r   <= '0;
      k_r     <= '0;
    end else begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      k_r     <= k_nxt;
    end
  end

  a_final_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_entry.eop |=> phase_r == PH_IDLE)
    else $error("parser not idle after end of packet");

  a_eop_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_entry.eop == (push_entry.kind != KIND_PROPERTY)))
    else $error("end of packet flag disagrees with result kind");

  a_props_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PROPS |-> len_r != '0)
    else $error("property phase with zero bytes left");

endmodule

[sv/msp_queue.sv]
// ----------------------------------------------------------------------------
// msp_queue: result queue
// short fifo between parser and output stage
// ----------------------------------------------------------------------------
module msp_queue import msp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  entry_t  push_entry,
  output logic    q_ready,
  input  logic    pop,
  output logic    q_valid,
  output entry_t  head
);

  entry_t             mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign q_ready = count_r != QCNT_W'(QDEPTH);
  assign q_valid = count_r != '0;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

[sv/msp_back.sv]
// ----------------------------------------------------------------------------
// msp_back: output stage
// pulls results from the queue into the registered result channel
// ----------------------------------------------------------------------------
module msp_back import msp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  entry_t       head,
  output logic         pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  logic    valid_r;
  entry_t  data_r;

  assign pop = q_valid && (!valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= head;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {data_r.property_byte, data_r.reason_code, data_r.packet_id};
  assign out_tuser  = data_r.kind;
  assign out_tlast  = data_r.eop;

endmodule

[sv/mqtt_suback_parser.sv]
// ----------------------------------------------------------------------------
// mqtt_suback_parser: subscribe / unsubscribe acknowledgement header parser
// splits the variable header into packet id, property bytes and reason code
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                    | tuser          | tlast
//  in_     | in  | [7:0] data_byte                          | packet_start   | -
//  out_    | out | [15:0] id, [23:16] reason, [31:24] prop  | [1:0] kind     | end_of_packet
//
// one byte per clock while the queue has room; the queue is written at the edge
// that takes a byte and the output register loads from the queue once it is free,
// so a result passes through a queue entry and the output register to out_tvalid
// id bytes give no result, a length byte only an overlong one; others give at most one
// reset is synchronous, active low, and clears parse state and the queue
// in_tready drops only when the two-entry queue is full, so an output stall
// reaches the input once the output register and both queue entries hold results
//
module mqtt_suback_parser import msp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // input byte stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] packet_start
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // [15:0] packet_id, [23:16] reason_code, [31:24] property_byte
  output logic [1:0]   out_tuser,  // [1:0] result_kind
  output logic         out_tlast   // end_of_packet
);

  logic    push, pop, q_ready, q_valid;
  entry_t  push_entry, head;

  // front: takes bytes whenever the queue has room
  msp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_start   (in_tuser),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  assign in_tready = q_ready;

  // queue decouples parser from downstream stalls
  msp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  // back: registered result channel
  msp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/sv/suback_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// suback_result_checker: result predictor and comparator for the parser
// watches both stream channels, predicts the parser's results byte by byte
// and compares each result transaction with the oldest expected one
// ----------------------------------------------------------------------------
module suback_result_checker import msp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          results_pending
);

  typedef enum logic [2:0] {
    ST_ID_HIGH,
    ST_ID_LOW,
    ST_LENGTH,
    ST_PROPS,
    ST_REASON,
    ST_IDLE
  } parse_state_t;

  parse_state_t     parse_state;
  logic [ID_W-1:0]  ident_acc;
  logic [LEN_W-1:0] length_acc;
  logic [LEN_W-1:0] bytes_left;
  logic [1:0]       groups_taken;
  entry_t           expected_results[$];

  initial mismatch_count = 0;
  initial results_pending = 0;

  task automatic clear_parse();
    parse_state  = ST_ID_HIGH;
    ident_acc    = '0;
    length_acc   = '0;
    bytes_left   = '0;
    groups_taken = '0;
  endtask

  // advance the parse by one accepted byte, queue the result it causes
  task automatic predict_byte(input logic [7:0] b, input logic start);
    entry_t r;
    if (start) clear_parse();
    r = '0;
    case (parse_state)
      ST_ID_HIGH: begin
        ident_acc   = {b, 8'h00};
        parse_state = ST_ID_LOW;
      end
      ST_ID_LOW: begin
        ident_acc[7:0] = b;
        parse_state    = ST_LENGTH;
      end
      ST_LENGTH: begin
        length_acc = length_acc | (LEN_W'(b[6:0]) << (7 * groups_taken));
        if (!b[7]) begin
          bytes_left  = length_acc;
          parse_state = (length_acc == '0) ? ST_REASON : ST_PROPS;
        end else if (groups_taken + 1 >= MAX_LEN_BYTES) begin
          // continuation still set on the last allowed length byte
          parse_state = ST_IDLE;
          r.kind      = KIND_MALFORMED;
          r.eop       = 1'b1;
          expected_results.push_back(r);
        end else begin
          groups_taken = groups_taken + 2'd1;
        end
      end
      ST_PROPS: begin
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) parse_state = ST_REASON;
        r.kind          = KIND_PROPERTY;
        r.property_byte = b;
        expected_results.push_back(r);
      end
      ST_REASON: begin
        parse_state   = ST_IDLE;
        r.kind        = KIND_COMPLETE;
        r.packet_id   = ident_acc;
        r.reason_code = b;
        r.eop         = 1'b1;
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    entry_t want;
    if (!rst_n) begin
      clear_parse();
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected: kind 0x%0h data 0x%0h",
                 out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.kind, out_tuser);
          check_field("packet_id", want.packet_id, out_tdata[15:0]);
          check_field("reason_code", want.reason_code, out_tdata[23:16]);
          check_field("property_byte", want.property_byte, out_tdata[31:24]);
          check_field("end_of_packet", want.eop, out_tlast);
        end
      end
    end
    results_pending <= expected_results.size();
  end

endmodule

[tb/sv/tb_mqtt_suback_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mqtt_suback_parser: testbench of the acknowledgement header parser
// drives directed and random byte streams (well-formed packets, overlong
// lengths, cut-off packets and noise) with bursty input and a stalling
// output; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_mqtt_suback_parser;

  localparam int ITEM_TARGET   = 2000;
  localparam int DRAIN_EVERY   = 300;   // sender pauses for a full drain this often
  localparam int LONG_HOLD     = 250;   // receiver hold-off that backs up the input
  localparam int TAIL_CYCLES   = 20;    // settle time after the last expected result
  localparam int MAX_LEN_BYTES_TB = msp_pkg::MAX_LEN_BYTES;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;   // [0] packet_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [15:0] packet_id, [23:16] reason_code, [31:24] property_byte
  logic [1:0]  out_tuser;           // [1:0] result_kind
  logic        out_tlast;           // end_of_packet

  int mismatch_count;
  int results_pending;
  int items_sent  = 0;
  int burst_left  = 0;

  always #6 clk = ~clk;

  mqtt_suback_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  suback_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  // one input transaction; bursts of random length with random gaps between
  // them, a zero gap keeps valid high across the burst boundary
  // bytes the parser just drops are not counted toward the item total
  task automatic send_byte(input logic [7:0] b, input logic start, input bit counted);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (counted) items_sent++;
  endtask

  // well-formed acknowledgement: id high, id low, length coded in len_bytes
  // groups (padded with continuation bytes when longer than needed),
  // random property bytes, then the reason code
  task automatic send_ack(input logic [15:0] id, input int prop_len, input int len_bytes,
                          input logic [7:0] reason, input logic start);
    send_byte(id[15:8], start, 1'b1);
    send_byte(id[7:0], 1'b0, 1'b1);
    for (int i = 0; i < len_bytes; i++)
      send_byte({1'(i < len_bytes - 1), 7'(prop_len >> (7 * i))}, 1'b0, 1'b1);
    for (int i = 0; i < prop_len; i++)
      send_byte(8'($urandom), 1'b0, 1'b1);
    send_byte(reason, 1'b0, 1'b1);
  endtask

  // id and a length field whose last allowed byte still has continuation set
  task automatic send_overlong(input logic [15:0] id);
    send_byte(id[15:8], 1'b1, 1'b1);
    send_byte(id[7:0], 1'b0, 1'b1);
    for (int i = 0; i < MAX_LEN_BYTES_TB; i++)
      send_byte({1'b1, 7'($urandom)}, 1'b0, 1'b1);
  endtask

  // sender stops offering until every expected result has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // reset, directed cases, random traffic and the verdict
  initial begin : stimulus
    int choice;
    int plen;
    int min_bytes;
    int next_drain;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no start mark after reset: parsed as a packet begun at reset, zero length
    send_ack(16'h1234, 0, 1, 8'h00, 1'b0);
    // bytes after the end are dropped
    send_byte(8'hFF, 1'b0, 1'b0);
    // all-ones id and reason, one property byte
    send_ack(16'hFFFF, 1, 1, 8'hFF, 1'b1);
    // zero id, zero length spread over three groups
    send_ack(16'h0000, 0, 3, 8'h80, 1'b1);
    // overlong length field, then a dropped byte
    send_overlong(16'hABCD);
    send_byte(8'h00, 1'b0, 1'b0);
    // packet cut off in its properties by a new start
    send_byte(8'h01, 1'b1, 1'b1);
    send_byte(8'h02, 1'b0, 1'b1);
    send_byte(8'h03, 1'b0, 1'b1);
    send_byte(8'h11, 1'b0, 1'b1);
    send_ack(16'h8001, 1, 1, 8'h7F, 1'b1);
    // full four-group length ending without continuation
    send_ack(16'h5AA5, 2, 4, 8'h01, 1'b1);
    wait_drained();

    next_drain = items_sent + DRAIN_EVERY;
    while (items_sent < ITEM_TARGET) begin
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        // well-formed packet, mostly short property lists
        case ($urandom_range(0, 19))
          0:       plen = $urandom_range(100, 300);
          1, 2, 3,
          4, 5:    plen = $urandom_range(5, 20);
          default: plen = $urandom_range(0, 4);
        endcase
        min_bytes = (plen < 128) ? 1 : 2;
        if ($urandom_range(0, 4) == 0)
          min_bytes = min_bytes + $urandom_range(0, MAX_LEN_BYTES_TB - min_bytes);
        send_ack(16'($urandom), plen, min_bytes, 8'($urandom), 1'b1);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0, 1'b0);
      end else if (choice < 80) begin
        send_overlong(16'($urandom));
      end else if (choice < 90) begin
        // broken packet: a start and a few random bytes, cut off by the next start
        send_byte(8'($urandom), 1'b1, 1'b1);
        repeat ($urandom_range(0, 5)) send_byte(8'($urandom), 1'b0, 1'b1);
      end else begin
        // noise with a sparse start flag
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom), 1'($urandom_range(0, 9) == 0), 1'b1);
      end
      if (items_sent >= next_drain) begin
        wait_drained();
        next_drain = items_sent + DRAIN_EVERY;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_mqtt_suback_parser passed");
    end else begin
      $display("tb_mqtt_suback_parser failed");
    end
    $finish;
  end

  // output backpressure: free-running, random and periodic stretches, short
  // hold-offs, and one long hold-off early on so the queue fills and the
  // input stalls while the sender keeps offering
  initial begin : receiver
    int cycle_no;
    int span;
    int mode;
    bit long_done;
    cycle_no  = 0;
    long_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!long_done && cycle_no >= 300) begin
        long_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        cycle_no += LONG_HOLD;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
        for (int k = 0; k < span; k++) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= ($urandom_range(0, 3) != 0);
            2:       out_tready <= ((k % 5) != 4);
            default: out_tready <= (k >= span / 3);
          endcase
          @(posedge clk);
        end
        cycle_no += span;
      end
    end
  end

  // run limit
  initial begin : watchdog
    #6_000_000;
    $display("tb_mqtt_suback_parser failed");
    $finish;
  end

endmodule

[sim.f]
sv/msp_pkg.sv
sv/msp_front.sv
sv/msp_queue.sv
sv/msp_back.sv
sv/mqtt_suback_parser.sv
tb/sv/suback_result_checker.sv
tb/sv/tb_mqtt_suback_parser.sv
